// File: sv/asc_pkg.sv
package asc_pkg;

    localparam int unsigned VAL_W   = 12;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned SUM_W   = 16;
    localparam int unsigned SIM_W   = 17;
    localparam int unsigned DEN_W   = 17;
    localparam int unsigned NUM_W   = SUM_W + 16;
    localparam int unsigned CRED_W  = 3;
    localparam int unsigned BIT_W   = $clog2(NUM_W);

    localparam int unsigned QDEPTH  = 2;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [VAL_W-1:0]  NEAR_DIST   = VAL_W'(4);
    localparam logic [VAL_W-1:0]  FAR_DIST    = VAL_W'(6);
    localparam logic [CRED_W-1:0] NEAR_FIFTHS = CRED_W'(5);
    localparam logic [CRED_W-1:0] FAR_FIFTHS  = CRED_W'(4);
    localparam logic [SUM_W-1:0]  SUM_MAX     = {SUM_W{1'b1}};
    localparam logic [SIM_W-1:0]  SCALE_ONE   = SIM_W'(65536);

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SAT,
        ST_OUT
    } t_back_state;

endpackage

// File: sv/asc_if.sv
interface asc_in_if;
    logic                              valid;
    logic                              ready;
    logic [asc_pkg::VAL_W-1:0]         first_value;
    logic [asc_pkg::VAL_W-1:0]         second_value;
    logic [asc_pkg::COUNT_W-1:0]       aligned_count;
    logic                              last;

    modport source (output valid, first_value, second_value, aligned_count, last,
                    input ready);
    modport sink   (input valid, first_value, second_value, aligned_count, last,
                    output ready);
endinterface

interface asc_out_if;
    logic                              valid;
    logic                              ready;
    logic [asc_pkg::SIM_W-1:0]         similarity;
    logic                              zero_count_error;

    modport source (output valid, similarity, zero_count_error, input ready);
    modport sink   (input valid, similarity, zero_count_error, output ready);
endinterface

// File: sv/asc_front.sv
module asc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    asc_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output asc_pkg::t_job o_job
);

    logic [asc_pkg::SUM_W-1:0]  r_sum;
    logic [asc_pkg::SUM_W-1:0]  n_sum;
    logic [asc_pkg::VAL_W-1:0]  abs_diff;
    logic [asc_pkg::CRED_W-1:0] credit;
    logic [asc_pkg::SUM_W:0]    sum_wide;
    logic                       accept;

    always_comb begin
        if (i_in.first_value >= i_in.second_value) begin
            abs_diff = i_in.first_value - i_in.second_value;
        end else begin
            abs_diff = i_in.second_value - i_in.first_value;
        end

        if (i_in.first_value == '0) begin
            credit = '0;
        end else if (abs_diff <= asc_pkg::NEAR_DIST) begin
            credit = asc_pkg::NEAR_FIFTHS;
        end else if (abs_diff <= asc_pkg::FAR_DIST) begin
            credit = asc_pkg::FAR_FIFTHS;
        end else begin
            credit = '0;
        end

        sum_wide = {1'b0, r_sum} + (asc_pkg::SUM_W + 1)'(credit);
        // hold at the top on an overlong run
        n_sum = sum_wide[asc_pkg::SUM_W] ? asc_pkg::SUM_MAX : sum_wide[asc_pkg::SUM_W-1:0];
    end

    // stall only while the queue has no room for a finished run
    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = accept && i_in.last;
    assign o_job      = '{sum: n_sum, count: i_in.aligned_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (accept) begin
            r_sum <= i_in.last ? '0 : n_sum;
        end
    end

endmodule

// File: sv/asc_queue.sv
module asc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  asc_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output asc_pkg::t_job o_job
);

    asc_pkg::t_job               r_mem [asc_pkg::QDEPTH];
    logic [asc_pkg::QPTR_W-1:0]  r_wr;
    logic [asc_pkg::QPTR_W-1:0]  r_rd;
    logic [asc_pkg::QCNT_W-1:0]  r_cnt;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (r_cnt == asc_pkg::QCNT_W'(asc_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == asc_pkg::QPTR_W'(asc_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == asc_pkg::QPTR_W'(asc_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// File: sv/asc_back.sv
module asc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  asc_pkg::t_job i_q_job,
    output logic          o_pop,
    asc_out_if.source     o_out
);

    asc_pkg::t_back_state       r_state;
    asc_pkg::t_back_state       n_state;
    logic [asc_pkg::NUM_W-1:0]  r_num;
    logic [asc_pkg::DEN_W-1:0]  r_rem;
    logic [asc_pkg::DEN_W-1:0]  r_den;
    logic [asc_pkg::BIT_W-1:0]  r_bit;
    logic [asc_pkg::SIM_W-1:0]  r_sim;
    logic                       r_err;

    logic [asc_pkg::DEN_W:0]    rem_shift;
    logic                       fits;
    logic [asc_pkg::DEN_W-1:0]  den_new;
    logic                       over;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            asc_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_state = (i_q_job.count == '0) ? asc_pkg::ST_OUT : asc_pkg::ST_DIV;
                end
            end
            asc_pkg::ST_DIV: begin
                if (r_bit == asc_pkg::BIT_W'(asc_pkg::NUM_W - 1)) begin
                    n_state = asc_pkg::ST_SAT;
                end
            end
            asc_pkg::ST_SAT: begin
                n_state = asc_pkg::ST_OUT;
            end
            asc_pkg::ST_OUT: begin
                if (o_out.ready) begin
                    n_state = asc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = asc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // restoring division, one quotient bit per cycle; quotient shifts into r_num
    always_comb begin
        rem_shift = {r_rem, r_num[asc_pkg::NUM_W-1]};
        fits      = (rem_shift >= {1'b0, r_den});
        den_new   = asc_pkg::DEN_W'(4 * asc_pkg::DEN_W'(i_q_job.count))
                  + asc_pkg::DEN_W'(asc_pkg::DEN_W'(i_q_job.count) * 1);
        over      = (|r_num[asc_pkg::NUM_W-1:asc_pkg::SIM_W])
                  || (r_num[asc_pkg::SIM_W-1] && (|r_num[asc_pkg::SIM_W-2:0]));
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            asc_pkg::ST_IDLE: begin
                r_num <= {i_q_job.sum, (asc_pkg::NUM_W - asc_pkg::SUM_W)'(0)};
                r_rem <= '0;
                r_den <= {den_new[asc_pkg::DEN_W-2:0], 1'b0};
                r_bit <= '0;
                r_sim <= '0;
                r_err <= 1'b1;
            end
            asc_pkg::ST_DIV: begin
                r_rem <= fits ? asc_pkg::DEN_W'(rem_shift - {1'b0, r_den})
                              : rem_shift[asc_pkg::DEN_W-1:0];
                r_num <= {r_num[asc_pkg::NUM_W-2:0], fits};
                r_bit <= r_bit + 1'b1;
            end
            asc_pkg::ST_SAT: begin
                r_sim <= over ? asc_pkg::SCALE_ONE : r_num[asc_pkg::SIM_W-1:0];
                r_err <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid            = (r_state == asc_pkg::ST_OUT);
    assign o_out.similarity       = r_sim;
    assign o_out.zero_count_error = r_err;

endmodule

// File: sv/alignment_similarity_score.sv
// Scores how closely two residue mappings agree. Elements stream in one per
// cycle, each with a first and a second value; each aligned element adds 5
// or 4 fifths of credit by distance, and the element flagged last closes the
// run. Input takes one element every cycle, including the last of a run, as
// long as the two-entry run queue has room. Each closed run then passes
// through the back end (a load, a shared bit-per-cycle divider, a saturate
// step and an output state), plus any wait for the output to be taken; a run
// with zero aligned count skips the divider and the saturate step. Runs
// shorter than the back-end time let the queue fill, and input then stalls
// until a run has left the queue.
module alignment_similarity_score (
    input  logic      i_clk,
    input  logic      i_rst_n,
    asc_in_if.sink    i_in,
    asc_out_if.source o_out
);

    logic          q_full;
    logic          q_push;
    logic          q_valid;
    logic          q_pop;
    asc_pkg::t_job push_job;
    asc_pkg::t_job head_job;

    asc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (push_job)
    );

    asc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    asc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (head_job),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

// File: sv/asc_checker.sv
module asc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [asc_pkg::SIM_W-1:0]   i_similarity,
    input logic                        i_zero_count_error
);

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_similarity)
                                        && $stable(i_zero_count_error))
        else $error("result changed while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_zero_count_error |-> i_similarity == '0)
        else $error("zero count result carries a nonzero similarity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_similarity <= asc_pkg::SCALE_ONE)
        else $error("similarity above full scale");

    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown straight after reset");

endmodule

bind alignment_similarity_score asc_checker u_asc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_similarity       (o_out.similarity),
    .i_zero_count_error (o_out.zero_count_error)
);

// File: sim/tb_top.sv
class run_score_tracker;
    typedef struct {
        logic [asc_pkg::SIM_W-1:0] similarity;
        logic                      zero_count_error;
    } score_t;

    logic [asc_pkg::SUM_W-1:0] credit_fifths;
    score_t                    scores_due[$];
    int                        mismatches;

    function new();
        credit_fifths = '0;
        mismatches    = 0;
    endfunction

    function logic [asc_pkg::CRED_W-1:0] element_credit(logic [asc_pkg::VAL_W-1:0] a,
                                                         logic [asc_pkg::VAL_W-1:0] b);
        logic [asc_pkg::VAL_W-1:0] abs_diff;
        if (a == '0) return '0;
        abs_diff = (a >= b) ? a - b : b - a;
        if (abs_diff <= asc_pkg::NEAR_DIST) return asc_pkg::NEAR_FIFTHS;
        if (abs_diff <= asc_pkg::FAR_DIST) return asc_pkg::FAR_FIFTHS;
        return '0;
    endfunction

    // Add the credit of one accepted request; on the last one, queue the run's score.
    function void note_element(logic [asc_pkg::VAL_W-1:0]   a,
                               logic [asc_pkg::VAL_W-1:0]   b,
                               logic [asc_pkg::COUNT_W-1:0] cnt,
                               logic                        lst);
        logic [asc_pkg::SUM_W:0] total;
        logic [63:0]             quotient;
        score_t                  score;
        total = {1'b0, credit_fifths} + (asc_pkg::SUM_W + 1)'(element_credit(a, b));
        if (total > {1'b0, asc_pkg::SUM_MAX}) total = {1'b0, asc_pkg::SUM_MAX};
        credit_fifths = total[asc_pkg::SUM_W-1:0];
        if (!lst) return;
        if (cnt == '0) begin
            score.similarity       = '0;
            score.zero_count_error = 1'b1;
        end else begin
            quotient = (64'(credit_fifths) * 64'(asc_pkg::SCALE_ONE)) / (64'(cnt) * 64'd10);
            if (quotient > 64'(asc_pkg::SCALE_ONE)) quotient = 64'(asc_pkg::SCALE_ONE);
            score.similarity       = quotient[asc_pkg::SIM_W-1:0];
            score.zero_count_error = 1'b0;
        end
        scores_due.push_back(score);
        credit_fifths = '0;
    endfunction

    task report_mismatch(string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    task check_score(logic [asc_pkg::SIM_W-1:0] sim, logic zerr);
        score_t want;
        if (scores_due.size() == 0) begin
            report_mismatch($sformatf("score %0d flag %0b with no run closed", sim, zerr));
            return;
        end
        want = scores_due.pop_front();
        if (sim !== want.similarity)
            report_mismatch($sformatf("similarity %0d, wanted %0d", sim, want.similarity));
        if (zerr !== want.zero_count_error)
            report_mismatch($sformatf("zero count flag %0b, wanted %0b",
                                      zerr, want.zero_count_error));
    endtask

    task check_drained();
        if (scores_due.size() != 0)
            report_mismatch($sformatf("%0d scores never arrived", scores_due.size()));
    endtask
endclass

module tb_top;
    import asc_pkg::*;

    localparam int VAL_MAX      = (1 << VAL_W) - 1;
    localparam int COUNT_MAX    = 4096;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 1550;

    logic i_clk;
    logic i_rst_n;

    asc_in_if  in_if ();
    asc_out_if out_if ();

    run_score_tracker tracker = new();

    int src_gap_max;
    int snk_gap_max;
    bit hold_pending;

    alignment_similarity_score i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("TEST FAILED");
        $finish;
    end

    // Pick a second index at the given distance from a, kept inside the index range.
    function automatic logic [VAL_W-1:0] partner_at(logic [VAL_W-1:0] a, int offset);
        int b;
        b = ($urandom_range(0, 1) == 0) ? int'(a) + offset : int'(a) - offset;
        if (b < 0) b = int'(a) + offset;
        if (b > VAL_MAX) b = int'(a) - offset;
        return VAL_W'(b);
    endfunction

    task automatic send_element(input logic [VAL_W-1:0]   a,
                                input logic [VAL_W-1:0]   b,
                                input logic [COUNT_W-1:0] cnt,
                                input logic               lst);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.first_value   <= a;
        in_if.second_value  <= b;
        in_if.aligned_count <= cnt;
        in_if.last          <= lst;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        tracker.note_element(a, b, cnt, lst);
    endtask

    initial begin : score_sink
        int gap;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        out_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                tracker.check_score(out_if.similarity, out_if.zero_count_error);
                gap = $urandom_range(0, snk_gap_max);
                // hold off long enough for the run queue to fill and stall the input
                if (hold_pending) begin
                    gap          = HOLD_CYCLES;
                    hold_pending = 1'b0;
                end
                if (gap > 0) begin
                    out_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                    out_if.ready <= 1'b1;
                end
            end
        end
    end

    initial begin : stimulus
        int                 sent;
        int                 len;
        int                 pick;
        int                 next_shuffle;
        bit                 second_hold;
        logic [VAL_W-1:0]   a;
        logic [VAL_W-1:0]   b;
        logic [COUNT_W-1:0] cnt;
        logic               lst;

        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.first_value   = '0;
        in_if.second_value  = '0;
        in_if.aligned_count = '0;
        in_if.last          = 1'b0;
        src_gap_max         = 2;
        snk_gap_max         = 2;
        hold_pending        = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unaligned skip, near, far and out-of-range distances, second index zero
        send_element(12'd0,    12'd4095, 13'd4096, 1'b0);
        send_element(12'd4095, 12'd4095, 13'd0,    1'b0);
        send_element(12'd1,    12'd5,    13'd1,    1'b0);
        send_element(12'd10,   12'd5,    13'd8191, 1'b0);
        send_element(12'd4095, 12'd4089, 13'd2,    1'b0);
        send_element(12'd7,    12'd0,    13'd5,    1'b0);
        send_element(12'd100,  12'd107,  13'd5,    1'b0);
        send_element(12'd4095, 12'd0,    13'd4096, 1'b1);
        // zero aligned count, with credit pending
        send_element(12'd3,    12'd3,    13'd0,    1'b1);
        // credit above the count: saturate
        send_element(12'd1,    12'd1,    13'd1,    1'b0);
        send_element(12'd2,    12'd3,    13'd1,    1'b0);
        send_element(12'd4095, 12'd4091, 13'd1,    1'b1);
        // credit that gives exactly full scale for the count
        send_element(12'd5,    12'd5,    13'd7,    1'b0);
        send_element(12'd9,    12'd9,    13'd1,    1'b1);
        // single-element runs, two of them with empty credit
        send_element(12'd0,    12'd0,    13'd4096, 1'b1);
        send_element(12'd0,    12'd4095, 13'd0,    1'b1);
        send_element(12'd2048, 12'd2054, 13'd3,    1'b1);

        hold_pending = 1'b1;
        second_hold  = 1'b0;
        sent         = 0;
        next_shuffle = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= next_shuffle) begin
                // zero means a stretch with no idling on that side
                src_gap_max  = $urandom_range(0, 4);
                snk_gap_max  = $urandom_range(0, 4);
                next_shuffle = sent + 150;
            end
            if (!second_hold && sent >= RANDOM_ITEMS / 2) begin
                hold_pending = 1'b1;
                second_hold  = 1'b1;
            end
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 80);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 9))
                    0:       a = VAL_W'(1);
                    1:       a = VAL_W'(VAL_MAX);
                    default: a = VAL_W'($urandom_range(1, VAL_MAX));
                endcase
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    a = '0;
                    b = VAL_W'($urandom_range(0, VAL_MAX));
                end else if (pick < 55) begin
                    b = partner_at(a, $urandom_range(0, 4));
                end else if (pick < 75) begin
                    b = partner_at(a, $urandom_range(5, 6));
                end else if (pick < 80) begin
                    b = partner_at(a, 7);
                end else if (pick < 88) begin
                    b = ($urandom_range(0, 1) == 0) ? VAL_W'(0) : VAL_W'(VAL_MAX);
                end else begin
                    b = VAL_W'($urandom_range(0, VAL_MAX));
                end
                lst  = (k == len - 1);
                pick = $urandom_range(0, 99);
                if (!lst)
                    cnt = COUNT_W'($urandom_range(0, COUNT_MAX));
                else if (pick < 8)
                    cnt = '0;
                else if (pick < 18)
                    cnt = COUNT_W'(COUNT_MAX);
                else if (pick < 48)
                    cnt = COUNT_W'($urandom_range(1, COUNT_MAX));
                else
                    cnt = COUNT_W'($urandom_range(1, len + 2));
                send_element(a, b, cnt, lst);
            end
            sent += len;
        end
        in_if.valid <= 1'b0;

        while (tracker.scores_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        tracker.check_drained();
        if (tracker.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
